// ===== sv/tip_pkg.sv =====
`default_nettype none

package tip_pkg;

  typedef struct packed {
    logic [63:0] value;
    logic [15:0] consumed;
    logic        range_error;
  } res_t;

  // All ones in the low 32 or 64 bits
  function automatic logic [63:0] width_mask(input logic wide);
    width_mask = wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
  endfunction

  // Magnitude of the most negative signed value of the width
  function automatic logic [63:0] half_range(input logic wide);
    half_range = wide ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
  endfunction

endpackage

`default_nettype wire

// ===== sv/tip_accum.sv =====
`default_nettype none

module tip_accum (
  input  wire logic [63:0] acc_i,
  input  wire logic        ovf_i,
  input  wire logic [5:0]  base_i,
  input  wire logic [5:0]  digit_i,
  input  wire logic        wide_i,
  input  wire logic        signed_i,
  output logic      [63:0] acc_o,
  output logic             ovf_o
);

  logic [69:0] mul;
  logic [70:0] sum;
  logic [63:0] lim;
  logic        over;

  // acc*base + digit > limit is the same test as the cutoff/remainder check
  assign mul  = {6'd0, acc_i} * {64'd0, base_i};
  assign sum  = {1'b0, mul} + {65'd0, digit_i};
  assign lim  = signed_i ? tip_pkg::half_range(wide_i) : tip_pkg::width_mask(wide_i);
  assign over = sum > {7'd0, lim};

  assign acc_o = over ? acc_i : sum[63:0];
  assign ovf_o = ovf_i | over;

endmodule

`default_nettype wire

// ===== sv/tip_emit.sv =====
`default_nettype none

module tip_emit (
  input  wire logic [63:0]  acc_i,
  input  wire logic         neg_i,
  input  wire logic         ovf_i,
  input  wire logic         wide_i,
  input  wire logic         signed_i,
  input  wire logic [15:0]  consumed_i,
  output tip_pkg::res_t     res_o
);

  logic [63:0] mask;
  logic [63:0] half;
  logic [63:0] bound;
  logic [63:0] neg_acc;
  logic [63:0] val;
  logic        err;

  assign mask    = tip_pkg::width_mask(wide_i);
  assign half    = tip_pkg::half_range(wide_i);
  assign bound   = neg_i ? half : half - 64'd1;
  assign neg_acc = 64'd0 - acc_i;

  always_comb begin
    err = 1'b0;
    if (signed_i) begin
      if (ovf_i || (acc_i > bound)) begin
        err = 1'b1;
        val = bound;
      end else begin
        val = neg_i ? neg_acc : acc_i;
      end
    end else if (ovf_i) begin
      err = 1'b1;
      val = mask;
    end else begin
      val = neg_i ? neg_acc : acc_i;
    end
  end

  assign res_o.value       = val & mask;
  assign res_o.consumed    = consumed_i;
  assign res_o.range_error = err;

endmodule

`default_nettype wire

// ===== sv/tip_skid.sv =====
`default_nettype none

module tip_skid (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire tip_pkg::res_t push_data_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output tip_pkg::res_t      out_data_o
);

  logic          out_valid_q;
  logic          skid_valid_q;
  tip_pkg::res_t out_q;
  tip_pkg::res_t skid_q;
  logic          take;

  assign take = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        // no push while the skid holds a request
        if (take) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (push_i) begin
        if (!out_valid_q || take) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (!out_valid_q || take) begin
        out_q <= push_data_i;
      end else begin
        skid_q <= push_data_i;
      end
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== sv/text_to_integer_parser.sv =====
// Streaming text-to-integer parser, one character per request.
// Throughput: one character per cycle while the output buffer is not full; the
// multiply-add and limit compare on the running value feed the state registers.
// A result is registered into the output buffer from the character that ends it.
// A two-entry output buffer lets characters flow while a result waits.
// Reset: idle, base 10, 64-bit, unsigned, output buffer empty.
`default_nettype none

module text_to_integer_parser #(
  parameter logic [31:0] COUNT_LIMIT = 32'd65535
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [5:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  ch_i,
  input  wire logic        start_req_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [63:0] value_o,
  output logic      [15:0] consumed_o,
  output logic             range_error_o
);

  localparam logic [15:0] CntCap =
    (COUNT_LIMIT < 32'd65535) ? COUNT_LIMIT[15:0] : 16'hFFFF;

  localparam logic [1:0] CfgNumberBase  = 2'd0;
  localparam logic [1:0] CfgResultWidth = 2'd1;
  localparam logic [1:0] CfgSignedMode  = 2'd2;

  typedef enum logic [2:0] {
    PhIdle,
    PhSpace,
    PhSigned,
    PhZero,
    PhZeroX,
    PhDigits
  } phase_e;

  function automatic logic [6:0] digit_of(input logic [7:0] c, input logic [5:0] b);
    logic       ok;
    logic [5:0] v;
    ok = 1'b1;
    v  = 6'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {2'b00, c[3:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 6'(c - 8'h61) + 6'd10;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      v = 6'(c - 8'h41) + 6'd10;
    end else begin
      ok = 1'b0;
    end
    ok = ok && (v < b) && (b >= 6'd2) && (b <= 6'd36);
    digit_of = {ok, v};
  endfunction

  logic [5:0]  number_base_q;
  logic        result_width_q;
  logic        signed_mode_q;

  phase_e      phase_q, phase_d;
  logic [63:0] acc_q, acc_d;
  logic [5:0]  base_q, base_d;
  logic        neg_q, neg_d;
  logic        ovf_q, ovf_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] zp_q, zp_d;

  phase_e      ph;
  logic [63:0] acc;
  logic [5:0]  base;
  logic        neg;
  logic        ovf;
  logic [15:0] cnt;
  logic [15:0] zp;

  logic        accept;
  logic        is_ws;
  logic        is_sign;
  logic        is_zero;
  logic        is_x;
  logic        base_zero;
  logic [15:0] cnt_inc;
  logic [16:0] zp_one;
  logic [15:0] zp_cons;
  logic [5:0]  wb;
  logic [6:0]  dig;
  logic        first_digit;
  logic        digits_step;
  logic        emit_v;
  logic        emit_zero;
  logic [15:0] emit_cnt;
  logic [63:0] acc_nx;
  logic        ovf_nx;
  logic [63:0] emit_acc;
  logic        emit_ovf;
  logic        buf_full;

  tip_pkg::res_t res;
  tip_pkg::res_t out_res;

  assign accept = in_valid_i & ~in_stall_o;

  always_comb begin
    if (start_req_i) begin
      ph   = PhSpace;
      acc  = 64'd0;
      neg  = 1'b0;
      ovf  = 1'b0;
      cnt  = 16'd0;
      zp   = 16'd0;
      base = number_base_q;
    end else begin
      ph   = phase_q;
      acc  = acc_q;
      neg  = neg_q;
      ovf  = ovf_q;
      cnt  = cnt_q;
      zp   = zp_q;
      base = base_q;
    end
  end

  assign is_ws     = (ch_i == 8'h20) || ((ch_i >= 8'h09) && (ch_i <= 8'h0D));
  assign is_sign   = (ch_i == 8'h2B) || (ch_i == 8'h2D);
  assign is_zero   = ch_i == 8'h30;
  assign is_x      = (ch_i == 8'h78) || (ch_i == 8'h58);
  assign base_zero = base == 6'd0;
  assign cnt_inc   = (cnt < CntCap) ? cnt + 16'd1 : cnt;
  assign zp_one    = {1'b0, zp} + 17'd1;
  assign zp_cons   = (zp_one > {1'b0, CntCap}) ? CntCap : zp_one[15:0];

  // base the digit is judged against in this phase
  always_comb begin
    case (ph)
      PhSpace, PhSigned: wb = base_zero ? 6'd10 : base;
      PhZero:            wb = base_zero ? 6'd8 : 6'd16;
      PhZeroX:           wb = 6'd16;
      default:           wb = base;
    endcase
  end

  assign dig = digit_of(ch_i, wb);

  tip_accum u_accum (
    .acc_i    (acc),
    .ovf_i    (ovf),
    .base_i   (wb),
    .digit_i  (dig[5:0]),
    .wide_i   (result_width_q),
    .signed_i (signed_mode_q),
    .acc_o    (acc_nx),
    .ovf_o    (ovf_nx)
  );

  always_comb begin
    phase_d     = ph;
    acc_d       = acc;
    base_d      = base;
    neg_d       = neg;
    ovf_d       = ovf;
    cnt_d       = cnt;
    zp_d        = zp;
    first_digit = 1'b0;
    digits_step = 1'b0;
    emit_v      = 1'b0;
    emit_zero   = 1'b0;
    emit_cnt    = cnt;

    case (ph)
      PhSpace: begin
        if (is_ws) begin
          cnt_d = cnt_inc;
        end else if (is_sign) begin
          neg_d   = ch_i == 8'h2D;
          cnt_d   = cnt_inc;
          phase_d = PhSigned;
        end else begin
          first_digit = 1'b1;
        end
      end
      PhSigned: first_digit = 1'b1;
      PhZero: begin
        if (is_x) begin
          cnt_d   = cnt_inc;
          phase_d = PhZeroX;
        end else begin
          base_d      = wb;
          phase_d     = PhDigits;
          digits_step = 1'b1;
        end
      end
      PhZeroX: begin
        if (!dig[6]) begin
          // prefix without a hex digit: roll back to the zero
          emit_v    = 1'b1;
          emit_zero = 1'b1;
          emit_cnt  = zp_cons;
          phase_d   = PhIdle;
        end else begin
          base_d  = wb;
          acc_d   = acc_nx;
          ovf_d   = ovf_nx;
          cnt_d   = cnt_inc;
          phase_d = PhDigits;
        end
      end
      PhDigits: digits_step = 1'b1;
      default: ;
    endcase

    if (first_digit) begin
      if ((base_zero || (base == 6'd16)) && is_zero) begin
        zp_d    = cnt;
        cnt_d   = cnt_inc;
        phase_d = PhZero;
      end else begin
        base_d = wb;
        if (!dig[6]) begin
          emit_v    = 1'b1;
          emit_zero = 1'b1;
          emit_cnt  = 16'd0;
          phase_d   = PhIdle;
        end else begin
          acc_d   = acc_nx;
          ovf_d   = ovf_nx;
          cnt_d   = cnt_inc;
          phase_d = PhDigits;
        end
      end
    end

    if (digits_step) begin
      if (!dig[6]) begin
        emit_v   = 1'b1;
        emit_cnt = cnt;
        phase_d  = PhIdle;
      end else begin
        acc_d = acc_nx;
        ovf_d = ovf_nx;
        cnt_d = cnt_inc;
      end
    end
  end

  assign emit_acc = emit_zero ? 64'd0 : acc;
  assign emit_ovf = emit_zero ? 1'b0 : ovf;

  tip_emit u_emit (
    .acc_i      (emit_acc),
    .neg_i      (neg),
    .ovf_i      (emit_ovf),
    .wide_i     (result_width_q),
    .signed_i   (signed_mode_q),
    .consumed_i (emit_cnt),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q  <= 6'd10;
      result_width_q <= 1'b1;
      signed_mode_q  <= 1'b0;
      phase_q        <= PhIdle;
      acc_q          <= 64'd0;
      base_q         <= 6'd0;
      neg_q          <= 1'b0;
      ovf_q          <= 1'b0;
      cnt_q          <= 16'd0;
      zp_q           <= 16'd0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CfgNumberBase:  number_base_q  <= cfg_wdata_i;
          CfgResultWidth: result_width_q <= cfg_wdata_i[0];
          CfgSignedMode:  signed_mode_q  <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (accept) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        base_q  <= base_d;
        neg_q   <= neg_d;
        ovf_q   <= ovf_d;
        cnt_q   <= cnt_d;
        zp_q    <= zp_d;
      end
    end
  end

  tip_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept & emit_v),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign in_stall_o    = buf_full;
  assign value_o       = out_res.value;
  assign consumed_o    = out_res.consumed;
  assign range_error_o = out_res.range_error;

endmodule

`default_nettype wire
